// ----- rtl/core/xnor_popcount_threshold_conv_top_defines.svh -----
// Assertion macros shared by the checker of the binary convolution block.
`ifndef XNOR_POPCOUNT_THRESHOLD_CONV_TOP_DEFINES_SVH
`define XNOR_POPCOUNT_THRESHOLD_CONV_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define XPC_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define XPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/xpc_pkg.sv -----
// Shared constants and types of the binary convolution block.
package xpc_pkg;

   localparam int WORD_BITS            = 32;
   localparam int DEF_MAX_KERNEL_BITS  = 4096;
   localparam int DEF_MAX_CHANNELS     = 1024;
   localparam int PC_W                 = 6;
   localparam int THR_W                = 16;
   localparam int IDX_W                = 7;
   localparam int KB_W                 = 13;
   localparam int OC_W                 = 11;
   localparam int OSB_W                = 5;
   localparam int CSR_INDEX_W          = 2;
   localparam int CSR_DATA_W           = 13;
   localparam int QUEUE_DEPTH          = 4;

   localparam logic [WORD_BITS-1:0] MSB_BIT = 32'h8000_0000;

   localparam logic [KB_W-1:0]  RESET_KERNEL_BITS   = 13'd32;
   localparam logic [OC_W-1:0]  RESET_OUT_CHANNELS  = 11'd32;
   localparam logic [OSB_W-1:0] RESET_OUT_START_BIT = 5'd0;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_BITS   = 2'd0,
      CSR_OUT_CHANNELS  = 2'd1,
      CSR_OUT_START_BIT = 2'd2
   } csr_index_type;

   // What the lanes found for one word, held between the lanes and the merge.
   typedef struct packed {
      logic                    last;
      logic                    chan_end;
      logic [PC_W-1:0]         pc_first;
      logic [PC_W-1:0]         pc_second;
      logic signed [THR_W-1:0] threshold;
   } lane_result_type;

   // Words emitted by one item, stream 0 before stream 1.
   typedef struct packed {
      logic                 has_first;
      logic                 has_second;
      logic                 final_word;
      logic [IDX_W-1:0]     index_first;
      logic [IDX_W-1:0]     index_second;
      logic [WORD_BITS-1:0] word_first;
      logic [WORD_BITS-1:0] word_second;
   } emit_type;

endpackage

// ----- rtl/core/xnor_popcount_threshold_conv_top.sv -----
// Top level of the binary XNOR-popcount convolution step for two timesteps.
//
// Input channel (req_): one transfer carries the aligned activation words of
// both timesteps, the shared weight word and the channel threshold. Each
// channel takes ceil(kernel_bits/32) transfers; the threshold is used on the
// last one. Output channel (rsp_): packed MSB-first output words, each to be
// ORed into memory at word_index; stream 0 precedes stream 1 within a channel
// and rsp_final_word marks the last word of a layer call.
// Configuration (csr_): always ready; a write to a register restarts the layer
// call and a write to the unused index is ignored. The user must issue writes
// only while the block is idle; the block itself does not enforce this.
// Throughput: one input transfer per cycle while req_stall is low. Two
// XNOR-popcount lanes feed the lane register ahead of the merge stage, which
// writes the words of a result into the queue, from whose head they are taken.
// Results leave one word per cycle, while rsp_stall is low, from a queue of four
// items; the input stalls once three queued items plus the one in the merge
// stage would fill it, either while rsp_stall holds or when transfers that
// each emit two words arrive back to back faster than the queue drains.
// Reset (synchronous) empties the pipeline and restores kernel_bits 32,
// out_channels 32 and out_start_bit 0.
module xnor_popcount_threshold_conv_top import xpc_pkg::*; #(
   parameter int MAX_KERNEL_BITS = DEF_MAX_KERNEL_BITS,
   parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WORD_BITS-1:0]   req_act_word_first,
   input  logic [WORD_BITS-1:0]   req_act_word_second,
   input  logic [WORD_BITS-1:0]   req_weight_word,
   input  logic signed [THR_W-1:0] req_threshold,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_stream_id,
   output logic [IDX_W-1:0]       rsp_word_index,
   output logic [WORD_BITS-1:0]   rsp_out_word,
   output logic                   rsp_final_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int NWORDS_MAX = (MAX_KERNEL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WC_W       = $clog2(NWORDS_MAX + 1);
   localparam int CC_W       = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W      = $clog2(MAX_KERNEL_BITS + 1);
   localparam int BP_W       = $clog2(WORD_BITS + 2 * MAX_CHANNELS);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers and their derived forms.
   logic [KB_W-1:0]  kernel_bits_ff,   kernel_bits_in;
   logic [OC_W-1:0]  out_channels_ff,  out_channels_in;
   logic [OSB_W-1:0] out_start_bit_ff, out_start_bit_in;
   logic [WC_W-1:0]  last_word_ff,     last_word_in;
   logic [4:0]       rem_ff,           rem_in;
   logic [CC_W-1:0]  last_chan_ff,     last_chan_in;
   logic [BP_W-1:0]  start_first_in,   start_second_in;
   logic             csr_write;
   logic             csr_known;
   logic             restart;

   // Input counters and the lane register.
   logic [WC_W-1:0]      word_cnt_ff, word_cnt_in;
   logic [CC_W-1:0]      chan_cnt_ff, chan_cnt_in;
   logic                 stage_valid_ff, stage_valid_in;
   lane_result_type      stage_ff, stage_in;
   logic                 req_accept;
   logic                 is_last;
   logic [WORD_BITS-1:0] mask;
   logic [PC_W-1:0]      pc_first, pc_second;

   logic                 push;
   emit_type             entry;
   logic [CNT_W-1:0]     q_count;

   // Only a write that lands on a register restarts the layer call.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_known = (csr_index == CSR_KERNEL_BITS) || (csr_index == CSR_OUT_CHANNELS)
                   || (csr_index == CSR_OUT_START_BIT);
   assign restart   = reset || (csr_write && csr_known);

   // Register writes; effective kernel and channel counts are clamped here.
   always_comb begin
      int ek;
      int ec;
      kernel_bits_in   = kernel_bits_ff;
      out_channels_in  = out_channels_ff;
      out_start_bit_in = out_start_bit_ff;
      if (reset) begin
         kernel_bits_in   = RESET_KERNEL_BITS;
         out_channels_in  = RESET_OUT_CHANNELS;
         out_start_bit_in = RESET_OUT_START_BIT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KERNEL_BITS:   kernel_bits_in   = KB_W'(csr_data);
            CSR_OUT_CHANNELS:  out_channels_in  = OC_W'(csr_data);
            CSR_OUT_START_BIT: out_start_bit_in = OSB_W'(csr_data);
            default:           kernel_bits_in   = kernel_bits_ff;
         endcase
      end
      if (kernel_bits_in == '0) begin
         ek = 1;
      end else if (int'(kernel_bits_in) > MAX_KERNEL_BITS) begin
         ek = MAX_KERNEL_BITS;
      end else begin
         ek = int'(kernel_bits_in);
      end
      if (out_channels_in == '0) begin
         ec = 1;
      end else if (int'(out_channels_in) > MAX_CHANNELS) begin
         ec = MAX_CHANNELS;
      end else begin
         ec = int'(out_channels_in);
      end
      last_word_in    = WC_W'((ek - 1) >> 5);
      rem_in          = 5'(ek);
      last_chan_in    = CC_W'(ec - 1);
      start_first_in  = BP_W'(out_start_bit_in);
      start_second_in = BP_W'(int'(out_start_bit_in) + ec);
   end

   always_ff @(posedge clock) begin
      kernel_bits_ff   <= kernel_bits_in;
      out_channels_ff  <= out_channels_in;
      out_start_bit_ff <= out_start_bit_in;
      last_word_ff     <= last_word_in;
      rem_ff           <= rem_in;
      last_chan_ff     <= last_chan_in;
   end

   // Input transfer, last-word mask and the word and channel counters.
   always_comb begin
      req_stall  = (int'(q_count) + int'(stage_valid_ff)) >= QUEUE_DEPTH;
      req_accept = req_valid && !req_stall;
      is_last    = word_cnt_ff == last_word_ff;
      if (is_last && rem_ff != '0) begin
         mask = {WORD_BITS{1'b1}} << (6'(WORD_BITS) - {1'b0, rem_ff});
      end else begin
         mask = {WORD_BITS{1'b1}};
      end
      word_cnt_in = word_cnt_ff;
      chan_cnt_in = chan_cnt_ff;
      if (restart) begin
         word_cnt_in = '0;
         chan_cnt_in = '0;
      end else if (req_accept) begin
         if (is_last) begin
            word_cnt_in = '0;
            chan_cnt_in = (chan_cnt_ff == last_chan_ff) ? '0 : chan_cnt_ff + CC_W'(1);
         end else begin
            word_cnt_in = word_cnt_ff + WC_W'(1);
         end
      end
      stage_valid_in     = req_accept && !restart;
      stage_in.last      = is_last;
      stage_in.chan_end  = is_last && (chan_cnt_ff == last_chan_ff);
      stage_in.pc_first  = pc_first;
      stage_in.pc_second = pc_second;
      stage_in.threshold = req_threshold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_cnt_ff    <= '0;
         chan_cnt_ff    <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         word_cnt_ff    <= word_cnt_in;
         chan_cnt_ff    <= chan_cnt_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   // One lane per timestep, both on the shared weight word.
   xpc_lane u_lane_first (
      .act_word    (req_act_word_first),
      .weight_word (req_weight_word),
      .mask        (mask),
      .count       (pc_first)
   );

   xpc_lane u_lane_second (
      .act_word    (req_act_word_second),
      .weight_word (req_weight_word),
      .mask        (mask),
      .count       (pc_second)
   );

   xpc_merge #(
      .SUM_W (SUM_W),
      .BP_W  (BP_W)
   ) u_merge (
      .clock        (clock),
      .restart      (restart),
      .start_first  (start_first_in),
      .start_second (start_second_in),
      .stage_valid  (stage_valid_ff),
      .stage        (stage_ff),
      .push         (push),
      .entry        (entry)
   );

   xpc_outq u_outq (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .entry          (entry),
      .count          (q_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_stream_id  (rsp_stream_id),
      .rsp_word_index (rsp_word_index),
      .rsp_out_word   (rsp_out_word),
      .rsp_final_word (rsp_final_word)
   );

endmodule

// ----- rtl/core/xpc_lane.sv -----
// One XNOR-popcount lane: counts matching bits of an activation and weight word.
module xpc_lane import xpc_pkg::*; (
   input  logic [WORD_BITS-1:0] act_word,
   input  logic [WORD_BITS-1:0] weight_word,
   input  logic [WORD_BITS-1:0] mask,
   output logic [PC_W-1:0]      count
);

   logic [WORD_BITS-1:0] match;
   logic [WORD_BITS-1:0] pairs;
   logic [WORD_BITS-1:0] nibbles;
   logic [WORD_BITS-1:0] bytes_sum;

   // Matching bits, then a tree of pair, nibble and byte sums.
   always_comb begin
      match     = ~(act_word ^ weight_word) & mask;
      pairs     = match - ((match >> 1) & 32'h5555_5555);
      nibbles   = (pairs & 32'h3333_3333) + ((pairs >> 2) & 32'h3333_3333);
      bytes_sum = (nibbles + (nibbles >> 4)) & 32'h0F0F_0F0F;
      count     = PC_W'(bytes_sum[7:0]) + PC_W'(bytes_sum[15:8])
                + PC_W'(bytes_sum[23:16]) + PC_W'(bytes_sum[31:24]);
   end

endmodule

// ----- rtl/core/xpc_merge.sv -----
// Merge stage: accumulates lane counts, thresholds and packs the output bits.
module xpc_merge import xpc_pkg::*; #(
   parameter int SUM_W = 13,
   parameter int BP_W  = 12
) (
   input  logic            clock,
   input  logic            restart,
   input  logic [BP_W-1:0] start_first,
   input  logic [BP_W-1:0] start_second,
   input  logic            stage_valid,
   input  lane_result_type stage,
   output logic            push,
   output emit_type        entry
);

   localparam int CMP_W = (SUM_W + 1 > THR_W) ? SUM_W + 1 : THR_W;

   logic [SUM_W-1:0]     sum_first_ff,    sum_first_in;
   logic [SUM_W-1:0]     sum_second_ff,   sum_second_in;
   logic [WORD_BITS-1:0] pack_first_ff,   pack_first_in;
   logic [WORD_BITS-1:0] pack_second_ff,  pack_second_in;
   logic [BP_W-1:0]      bitpos_first_ff, bitpos_first_in;
   logic [BP_W-1:0]      bitpos_second_ff, bitpos_second_in;

   logic [SUM_W-1:0]        total_first, total_second;
   logic signed [CMP_W-1:0] cmp_first, cmp_second, cmp_thr;
   logic                    bit_first, bit_second;
   logic [WORD_BITS-1:0]    set_first, set_second;
   logic                    emit_first, emit_second;
   logic                    take;

   // Running sums and the threshold decision of both timesteps.
   always_comb begin
      total_first  = sum_first_ff + SUM_W'(stage.pc_first);
      total_second = sum_second_ff + SUM_W'(stage.pc_second);
      cmp_first    = signed'(CMP_W'(total_first));
      cmp_second   = signed'(CMP_W'(total_second));
      cmp_thr      = CMP_W'(stage.threshold);
      bit_first    = cmp_first >= cmp_thr;
      bit_second   = cmp_second >= cmp_thr;
   end

   // Bit placement, MSB first; a word goes out when full or at the layer end.
   always_comb begin
      take        = stage_valid && stage.last;
      set_first   = bit_first ? (pack_first_ff | (MSB_BIT >> bitpos_first_ff[4:0]))
                              : pack_first_ff;
      set_second  = bit_second ? (pack_second_ff | (MSB_BIT >> bitpos_second_ff[4:0]))
                               : pack_second_ff;
      emit_first  = (bitpos_first_ff[4:0] == 5'd31) || stage.chan_end;
      emit_second = (bitpos_second_ff[4:0] == 5'd31) || stage.chan_end;

      push               = take && (emit_first || emit_second);
      entry.has_first    = emit_first;
      entry.has_second   = emit_second;
      entry.final_word   = stage.chan_end;
      entry.index_first  = IDX_W'(bitpos_first_ff >> 5);
      entry.index_second = IDX_W'(bitpos_second_ff >> 5);
      entry.word_first   = set_first;
      entry.word_second  = set_second;
   end

   // Next state of the sums, the packing words and the bit positions.
   always_comb begin
      sum_first_in     = sum_first_ff;
      sum_second_in    = sum_second_ff;
      pack_first_in    = pack_first_ff;
      pack_second_in   = pack_second_ff;
      bitpos_first_in  = bitpos_first_ff;
      bitpos_second_in = bitpos_second_ff;
      if (restart) begin
         sum_first_in     = '0;
         sum_second_in    = '0;
         pack_first_in    = '0;
         pack_second_in   = '0;
         bitpos_first_in  = start_first;
         bitpos_second_in = start_second;
      end else if (stage_valid) begin
         if (stage.last) begin
            sum_first_in  = '0;
            sum_second_in = '0;
            if (stage.chan_end) begin
               pack_first_in    = '0;
               pack_second_in   = '0;
               bitpos_first_in  = start_first;
               bitpos_second_in = start_second;
            end else begin
               pack_first_in    = emit_first ? '0 : set_first;
               pack_second_in   = emit_second ? '0 : set_second;
               bitpos_first_in  = bitpos_first_ff + BP_W'(1);
               bitpos_second_in = bitpos_second_ff + BP_W'(1);
            end
         end else begin
            sum_first_in  = total_first;
            sum_second_in = total_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_first_ff     <= sum_first_in;
      sum_second_ff    <= sum_second_in;
      pack_first_ff    <= pack_first_in;
      pack_second_ff   <= pack_second_in;
      bitpos_first_ff  <= bitpos_first_in;
      bitpos_second_ff <= bitpos_second_in;
   end

endmodule

// ----- rtl/core/xpc_outq.sv -----
// Result queue: holds up to four items and hands out one word a cycle unless stalled.
module xpc_outq import xpc_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  emit_type                          entry,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_stream_id,
   output logic [IDX_W-1:0]                  rsp_word_index,
   output logic [WORD_BITS-1:0]              rsp_out_word,
   output logic                              rsp_final_word
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   emit_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 phase_ff, phase_in;
   emit_type             head;
   logic                 show_second;
   logic                 xfer;
   logic                 pop;

   // Head entry: stream 0 word first, then stream 1 word.
   always_comb begin
      head           = slot_ff[rd_ptr_ff];
      show_second    = phase_ff || !head.has_first;
      rsp_valid      = count_ff != '0;
      rsp_stream_id  = show_second;
      rsp_word_index = show_second ? head.index_second : head.index_first;
      rsp_out_word   = show_second ? head.word_second : head.word_first;
      rsp_final_word = show_second && head.final_word;
      count          = count_ff;
   end

   // Pointer, count and phase updates.
   always_comb begin
      xfer      = rsp_valid && !rsp_stall;
      pop       = xfer && (show_second || !head.has_second);
      phase_in  = pop ? 1'b0 : (xfer ? 1'b1 : phase_ff);
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- rtl/core/xpc_checker.sv -----
// Port-level checker of the binary convolution block and its bind.
`include "xnor_popcount_threshold_conv_top_defines.svh"

module xpc_checker import xpc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_stream_id,
   input logic [IDX_W-1:0]     rsp_word_index,
   input logic [WORD_BITS-1:0] rsp_out_word,
   input logic                 rsp_final_word
);

   // The last word of a layer call always belongs to the second stream.
   `XPC_ASSERT(a_final_on_second, rsp_valid && rsp_final_word, rsp_stream_id, "final word not on stream 1")

   // A stalled result keeps its payload.
   `XPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_word) && $stable(rsp_stream_id) && $stable(rsp_word_index), "stalled result changed")

   // Leaving reset, nothing is pending and the input is open.
   `XPC_ASSERT(a_clean_after_reset, $past(reset), !rsp_valid && !req_stall, "state left over after reset")

   // The input stalls only while results wait on the output.
   `XPC_ASSERT(a_stall_needs_backlog, req_stall, rsp_valid, "input stalled with no pending result")

endmodule

bind xnor_popcount_threshold_conv_top xpc_checker u_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench of the binary XNOR-popcount convolution step for two timesteps.
module tb_top;
   import xpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LATENCY_DRAIN = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_ITEMS  = 40;

   // Index that names no register; a write to it must leave the layer call alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // One packed output word as it leaves the result channel.
   typedef struct packed {
      logic                 stream_id;
      logic [IDX_W-1:0]     word_index;
      logic [WORD_BITS-1:0] out_word;
      logic                 final_word;
   } bin_word_type;

   typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_type;

   // One row of the directed table: a register write or an input transfer,
   // with up to two hand-written expected words.
   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0]   csr_val;
      logic [WORD_BITS-1:0]    act_first;
      logic [WORD_BITS-1:0]    act_second;
      logic [WORD_BITS-1:0]    weight;
      logic signed [THR_W-1:0] thr;
      logic [1:0]              n_typed;
      bin_word_type            typed_first;
      bin_word_type            typed_second;
   } stim_row_type;

   localparam bin_word_type NONE = '0;

   localparam int DIR_ROWS = 27;
   localparam stim_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // Default settings after reset: the layer call is left unfinished.
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
        16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
        16'sd16, 2'd0, NONE, NONE},
      // One channel per call: both words of the call come out of every transfer.
      '{ROW_CFG, CSR_OUT_CHANNELS, 13'd1, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        16'sd32, 2'd2, '{1'b0, 7'd0, 32'h8000_0000, 1'b0}, '{1'b1, 7'd0, 32'h0, 1'b1}},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        16'sh8000, 2'd2, '{1'b0, 7'd0, 32'h8000_0000, 1'b0},
        '{1'b1, 7'd0, 32'h4000_0000, 1'b1}},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        16'sh7FFF, 2'd2, '{1'b0, 7'd0, 32'h0, 1'b0}, '{1'b1, 7'd0, 32'h0, 1'b1}},
      // Last start bit: the second stream crosses into the next word.
      '{ROW_CFG, CSR_OUT_START_BIT, 13'd31, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        16'sd0, 2'd2, '{1'b0, 7'd0, 32'h0000_0001, 1'b0},
        '{1'b1, 7'd1, 32'h8000_0000, 1'b1}},
      // A channel count of zero behaves as one channel.
      '{ROW_CFG, CSR_OUT_CHANNELS, 13'd0, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        16'sd33, 2'd2, '{1'b0, 7'd0, 32'h0, 1'b0}, '{1'b1, 7'd1, 32'h0, 1'b1}},
      // A kernel of zero bits behaves as one bit: only the MSB counts.
      '{ROW_CFG, CSR_KERNEL_BITS, 13'd0, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        16'sd1, 2'd2, '{1'b0, 7'd0, 32'h0000_0001, 1'b0}, '{1'b1, 7'd1, 32'h0, 1'b1}},
      // Two words per channel with a single leftover bit on the last one.
      '{ROW_CFG, CSR_OUT_START_BIT, 13'd0, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_CFG, CSR_KERNEL_BITS, 13'd33, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hDEAD_BEEF, 32'h0123_4567, 32'h5555_5555,
        16'sd17, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_0000, 32'h0000_FFFF, 32'hAAAA_AAAA,
        16'sd1, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hC3C3_C3C3, 32'h3C3C_3C3C, 32'hC3C3_C3C3,
        16'sd20, 2'd0, NONE, NONE},
      // A write to the unused index in the middle of a channel is ignored.
      '{ROW_CFG, CSR_UNUSED, 13'h1FFF, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000,
        16'sd20, 2'd0, NONE, NONE},
      // Three channels of two full words each.
      '{ROW_CFG, CSR_OUT_CHANNELS, 13'd3, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_CFG, CSR_KERNEL_BITS, 13'd64, 32'h0, 32'h0, 32'h0, 16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        16'sd64, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0000,
        16'sd0, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
        16'shFFFF, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h1357_9BDF, 32'h2468_ACE0, 32'h1357_9BDF,
        16'sd40, 2'd0, NONE, NONE},
      '{ROW_ITEM, CSR_UNUSED, 13'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
        16'sd32, 2'd0, NONE, NONE}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [WORD_BITS-1:0]    req_act_word_first;
   logic [WORD_BITS-1:0]    req_act_word_second;
   logic [WORD_BITS-1:0]    req_weight_word;
   logic signed [THR_W-1:0] req_threshold;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_stream_id;
   logic [IDX_W-1:0]        rsp_word_index;
   logic [WORD_BITS-1:0]    rsp_out_word;
   logic                    rsp_final_word;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   xnor_popcount_threshold_conv_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_act_word_first  (req_act_word_first),
      .req_act_word_second (req_act_word_second),
      .req_weight_word     (req_weight_word),
      .req_threshold       (req_threshold),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_stream_id       (rsp_stream_id),
      .rsp_word_index      (rsp_word_index),
      .rsp_out_word        (rsp_out_word),
      .rsp_final_word      (rsp_final_word),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // Predictor state: register copies and the layer call in progress.
   logic [KB_W-1:0]      cfg_kernel;
   logic [OC_W-1:0]      cfg_channels;
   logic [OSB_W-1:0]     cfg_start;
   logic [12:0]          sum_first;
   logic [12:0]          sum_second;
   logic [6:0]           word_count;
   logic [10:0]          chan_count;
   logic [WORD_BITS-1:0] pack [2];
   logic [11:0]          bit_pos [2];
   bin_word_type         pred_words [2];

   bin_word_type expected_words [$];
   int           error_count;
   int           cycle_count;
   bit           no_idle;
   int           hold_requests;
   int           holds_served;
   int           hold_left;
   int           burst_left;

   // Free-running clock, 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic int unsigned eff_kernel(logic [KB_W-1:0] kb);
      if (kb == 0) return 1;
      if (kb > DEF_MAX_KERNEL_BITS) return DEF_MAX_KERNEL_BITS;
      return kb;
   endfunction

   function automatic int unsigned eff_channels(logic [OC_W-1:0] oc);
      if (oc == 0) return 1;
      if (oc > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
      return oc;
   endfunction

   // Returns the predictor to the start of a layer call.
   function automatic void restart_layer();
      sum_first  = '0;
      sum_second = '0;
      word_count = '0;
      chan_count = '0;
      pack[0]    = '0;
      pack[1]    = '0;
      bit_pos[0] = 12'(cfg_start);
      bit_pos[1] = 12'(cfg_start + eff_channels(cfg_channels));
   endfunction

   // Register write as the block sees it; the unused index changes nothing.
   function automatic void set_register(logic [CSR_INDEX_W-1:0] idx,
                                        logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_KERNEL_BITS:   cfg_kernel   = val[KB_W-1:0];
         CSR_OUT_CHANNELS:  cfg_channels = val[OC_W-1:0];
         CSR_OUT_START_BIT: cfg_start    = val[OSB_W-1:0];
         default:           return;
      endcase
      restart_layer();
   endfunction

   // Accumulates one word for both timesteps; on the last word of a channel it
   // thresholds the sums and packs the two bits. Returns the number of words
   // emitted into pred_words.
   function automatic int conv_step(logic [31:0] a0, logic [31:0] a1, logic [31:0] w,
                                    logic signed [15:0] thr);
      int unsigned k_eff;
      int unsigned n_words;
      logic [4:0]  rem;
      logic [31:0] mask;
      logic        last_word;
      logic        layer_done;
      logic [1:0]  bits;
      int          n;
      k_eff     = eff_kernel(cfg_kernel);
      n_words   = (k_eff + 31) / 32;
      last_word = (int'(word_count) + 1) >= n_words;
      rem       = k_eff[4:0];
      mask      = '1;
      if (last_word && rem != 0) mask = '1 << (32 - rem);
      sum_first  += 13'($countones(~(a0 ^ w) & mask));
      sum_second += 13'($countones(~(a1 ^ w) & mask));
      if (!last_word) begin
         word_count++;
         return 0;
      end
      bits[0]    = int'(sum_first) >= int'(thr);
      bits[1]    = int'(sum_second) >= int'(thr);
      word_count = '0;
      sum_first  = '0;
      sum_second = '0;
      chan_count++;
      layer_done = chan_count >= eff_channels(cfg_channels);
      n = 0;
      // Stream 0 first; a word leaves when its last bit fills or the call ends.
      for (int s = 0; s < 2; s++) begin
         if (bits[s]) pack[s] |= MSB_BIT >> bit_pos[s][4:0];
         if (bit_pos[s][4:0] == 5'd31 || layer_done) begin
            pred_words[n] = '{stream_id: s[0], word_index: bit_pos[s][11:5],
                              out_word: pack[s], final_word: 1'b0};
            pack[s] = '0;
            n++;
         end
         bit_pos[s]++;
      end
      if (layer_done) begin
         pred_words[n-1].final_word = 1'b1;
         restart_layer();
      end
      return n;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // Result checking and receiver stalls, both decided at the rising edge.
   always @(posedge clock) begin
      bin_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_out_word, '0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_stream_id !== want.stream_id)
               report_mismatch("stream_id", rsp_stream_id, want.stream_id);
            if (rsp_word_index !== want.word_index)
               report_mismatch("word_index", rsp_word_index, want.word_index);
            if (rsp_out_word !== want.out_word)
               report_mismatch("out_word", rsp_out_word, want.out_word);
            if (rsp_final_word !== want.final_word)
               report_mismatch("final_word", rsp_final_word, want.final_word);
         end
      end
      // A requested hold-off takes priority over the random bursts.
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Register write, issued only once the block has drained.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY_DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      set_register(idx, val);
   endtask

   // One input transfer, possibly after an idle burst; the prediction is queued
   // unless the caller supplies hand-written expectations.
   task automatic send_item(input logic [31:0] a0, a1, w, input logic signed [15:0] thr,
                            input bit keep_prediction);
      int gap;
      int n;
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_act_word_first  <= a0;
      req_act_word_second <= a1;
      req_weight_word     <= w;
      req_threshold       <= thr;
      do @(posedge clock); while (req_stall);
      n = conv_step(a0, a1, w, thr);
      if (keep_prediction)
         for (int i = 0; i < n; i++) expected_words.push_back(pred_words[i]);
   endtask

   // Activation word that matches, inverts or ignores the weight word.
   function automatic logic [31:0] act_near(logic [31:0] w);
      case ($urandom_range(0, 3))
         0:       return w;
         1:       return ~w;
         default: return $urandom;
      endcase
   endfunction

   // Programs all three registers, then streams random words.
   task automatic run_phase(logic [CSR_DATA_W-1:0] kb_val, logic [CSR_DATA_W-1:0] ch_val,
                            logic [CSR_DATA_W-1:0] start_val, int n_items, int pause_at,
                            bit hold_output);
      logic [31:0]        w;
      logic [31:0]        a0;
      logic [31:0]        a1;
      logic signed [15:0] thr;
      write_csr(CSR_KERNEL_BITS, kb_val);
      write_csr(CSR_OUT_CHANNELS, ch_val);
      write_csr(CSR_OUT_START_BIT, start_val);
      if (hold_output) hold_requests++;
      for (int i = 0; i < n_items; i++) begin
         w  = $urandom;
         a0 = act_near(w);
         a1 = act_near(w);
         // Mostly thresholds within reach of the sums, sometimes any value.
         if ($urandom_range(0, 7) == 0) thr = 16'($urandom);
         else thr = 16'($urandom_range(0, eff_kernel(cfg_kernel) + 1));
         // Sender pause until every expected word has arrived.
         if (i == pause_at) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_words.size() != 0) @(posedge clock);
         end
         send_item(a0, a1, w, thr, 1'b1);
      end
   endtask

   // Timeout guard.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      logic [CSR_DATA_W-1:0] kb_val;
      logic [CSR_DATA_W-1:0] ch_val;
      int                    layer;
      int                    n_items;
      int                    rand_items;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_act_word_first  <= '0;
      req_act_word_second <= '0;
      req_weight_word     <= '0;
      req_threshold       <= '0;
      rsp_stall           <= 1'b0;
      csr_valid           <= 1'b0;
      csr_index           <= '0;
      csr_data            <= '0;
      cfg_kernel   = RESET_KERNEL_BITS;
      cfg_channels = RESET_OUT_CHANNELS;
      cfg_start    = RESET_OUT_START_BIT;
      restart_layer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
            write_csr(DIRECTED_ROWS[r].csr_idx, DIRECTED_ROWS[r].csr_val);
         end else begin
            send_item(DIRECTED_ROWS[r].act_first, DIRECTED_ROWS[r].act_second,
                      DIRECTED_ROWS[r].weight, DIRECTED_ROWS[r].thr,
                      DIRECTED_ROWS[r].n_typed == 0);
            if (DIRECTED_ROWS[r].n_typed > 0)
               expected_words.push_back(DIRECTED_ROWS[r].typed_first);
            if (DIRECTED_ROWS[r].n_typed > 1)
               expected_words.push_back(DIRECTED_ROWS[r].typed_second);
         end
      end

      // Extremes: saturated channel count with the last start bit.
      run_phase(13'd1, 13'h07FF, 13'd31, 10, -1, 1'b0);

      // Random settings, mostly whole layer calls, sometimes with extra items that run into the next call.
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       kb_val = 13'd0;
            1:       kb_val = 13'd31;
            2:       kb_val = 13'd32;
            3:       kb_val = 13'd33;
            4:       kb_val = 13'd64;
            default: kb_val = 13'($urandom_range(1, 96));
         endcase
         ch_val = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
         if ($urandom_range(0, 3) == 0) ch_val[12:11] = 2'($urandom);
         layer   = int'((eff_kernel(kb_val) + 31) / 32 * eff_channels(ch_val[OC_W-1:0]));
         n_items = layer;
         if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, layer);
         run_phase(kb_val, ch_val, 13'($urandom), n_items, -1, 1'b0);
         rand_items += n_items;
      end

      // Back-pressure: long receiver hold-off, then a sender pause mid-phase.
      no_idle = 1'b1;
      run_phase(13'd1, 13'd1, 13'd5, 24, 12, 1'b1);

      // Closing stretch without idling on either side.
      run_phase(13'd40, 13'd5, 13'd7, 12, -1, 1'b0);

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY_DRAIN) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/xpc_pkg.sv
rtl/core/xpc_lane.sv
rtl/core/xpc_merge.sv
rtl/core/xpc_outq.sv
rtl/core/xnor_popcount_threshold_conv_top.sv
rtl/core/xpc_checker.sv
test/tb_top.sv
